// ===== rtl/dvrt_pkg.sv =====
// Shared types and constants of the distance-vector route table.
// Used by distance_vector_route_table; no dependencies.
package dvrt_pkg;

  // Fixed field widths of the ports
  localparam int IDX_W       = 5;
  localparam int OP_W        = 2;
  localparam int PORT_COST_W = 16;
  localparam int OWN_W       = 5;
  localparam int CFG_W       = 6;
  localparam int CFG_IDX_W   = 1;

  localparam logic [OP_W-1:0] OP_ADVERTISE   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_LINK    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_LINK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_INDEX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 6'd32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_COLUMN,
    ST_SCAN,
    ST_ROW_DONE,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/dvrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write. No dependencies.
module dvrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/distance_vector_route_table.sv =====
// Distance-vector route table of one router: cost per destination and first hop.
// Depends on dvrt_pkg and dvrt_ram.
//
// One item in, one result out, one item at a time. The cost table lives in a
// single RAM ({dest, via} address) and every item is served by one sequencer
// around one saturating adder and one compare unit. With n the active node
// count, an advertised entry or a set-link item writes its entry and then
// scans its row, reading one via entry per cycle through the RAM read port
// for the n active vias. A remove-link item sweeps the link's column over all
// MAX_NODES rows and then rescans every active row. An ignored item goes
// straight to the done state. The sequencer holds in the done state until
// the output register is free. After reset the table is cleared to infinity
// one entry a cycle; no item is taken meanwhile, config writes are. The
// result sits in an output register, so the next item is accepted while it
// waits.
module distance_vector_route_table #(
  parameter int MAX_NODES = 32,
  parameter int COST_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // config
  input  logic                                  cfg_write,
  input  logic [dvrt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dvrt_pkg::CFG_W-1:0]            cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dvrt_pkg::OP_W-1:0]             opcode,
  input  logic [dvrt_pkg::IDX_W-1:0]            neighbor,
  input  logic [dvrt_pkg::IDX_W-1:0]            destination,
  input  logic [dvrt_pkg::PORT_COST_W-1:0]      cost_value,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dvrt_pkg::IDX_W-1:0]            route_dest,
  output logic [dvrt_pkg::PORT_COST_W-1:0]      best_cost,
  output logic [dvrt_pkg::IDX_W-1:0]            next_hop,
  output logic                                  reachable,
  output logic                                  changed,
  output logic                                  ignored
);

  localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int CMP_W     = (CNT_W > dvrt_pkg::CFG_W) ? CNT_W : dvrt_pkg::CFG_W;
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam logic [COST_BITS-1:0] INF     = '1;
  localparam logic [CMP_W-1:0]     MAX_CNT = CMP_W'(MAX_NODES);

  // config registers
  logic [dvrt_pkg::OWN_W-1:0] own_index;
  logic [dvrt_pkg::CFG_W-1:0] node_count;
  logic [CMP_W-1:0]           n_eff;

  // small stores
  logic                 neighbor_valid [MAX_NODES];
  logic [COST_BITS-1:0] link_cost      [MAX_NODES];
  logic [COST_BITS-1:0] row_minimum    [MAX_NODES];

  dvrt_pkg::state_t state, state_next;

  // item registers
  logic [dvrt_pkg::OP_W-1:0]  op_q;
  logic [dvrt_pkg::IDX_W-1:0] nb_q;
  logic [dvrt_pkg::IDX_W-1:0] ds_q;
  logic [COST_BITS-1:0]       cv_q;
  logic                       ign_q;
  logic [NODE_W-1:0]          nbi;
  logic [NODE_W-1:0]          row_i;
  logic                       link_op;

  // datapath
  logic [COST_BITS-1:0] wval;
  logic                 chg;
  logic [COST_BITS-1:0] m_acc;
  logic [NODE_W-1:0]    hop_acc;
  logic [NODE_W-1:0]    scan_row;
  logic [CMP_W-1:0]     cnt;
  logic                 pend;
  logic [NODE_W-1:0]    pend_via;
  logic [ADDR_W-1:0]    clr_cnt;
  logic [COST_BITS-1:0] res_best;
  logic [NODE_W-1:0]    res_hop;
  logic                 res_route;

  // shared arithmetic
  logic [COST_BITS:0]   sum;
  logic [COST_BITS-1:0] sat_sum;
  logic [COST_BITS-1:0] cand;

  // accept-time checks
  logic              nb_ok, ds_ok, ign_c;
  logic [NODE_W-1:0] nb_port_i;

  // RAM ports
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [COST_BITS-1:0] ram_wdata, rd_data;

  logic in_acc, out_load;

  dvrt_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_cost_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign n_eff = (CMP_W'(node_count) > MAX_CNT) ? MAX_CNT : CMP_W'(node_count);

  assign nbi     = NODE_W'(nb_q);
  assign link_op = (op_q == dvrt_pkg::OP_SET_LINK) || (op_q == dvrt_pkg::OP_REMOVE_LINK);
  assign row_i   = link_op ? nbi : NODE_W'(ds_q);

  assign sum     = {1'b0, link_cost[nbi]} + {1'b0, cv_q};
  assign sat_sum = (sum >= {1'b0, INF}) ? INF : sum[COST_BITS-1:0];
  assign cand    = neighbor_valid[pend_via] ? rd_data : INF;

  assign nb_port_i = NODE_W'(neighbor);
  assign nb_ok     = CMP_W'(neighbor) < n_eff;
  assign ds_ok     = CMP_W'(destination) < n_eff;

  always_comb begin
    unique case (opcode)
      dvrt_pkg::OP_ADVERTISE:
        ign_c = !(nb_ok && ds_ok && (destination != own_index) && neighbor_valid[nb_port_i]);
      dvrt_pkg::OP_SET_LINK, dvrt_pkg::OP_REMOVE_LINK:
        ign_c = !(nb_ok && (neighbor != own_index));
      default:
        ign_c = 1'b1;
    endcase
  end

  assign in_ready = (state == dvrt_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == dvrt_pkg::ST_DONE) && (!out_valid || out_ready);

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      own_index  <= '0;
      node_count <= dvrt_pkg::NODE_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dvrt_pkg::CFG_OWN_INDEX:  own_index  <= cfg_data[dvrt_pkg::OWN_W-1:0];
        dvrt_pkg::CFG_NODE_COUNT: node_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dvrt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and RAM control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = {row_i, nbi};
    ram_wdata  = INF;
    ram_raddr  = {row_i, nbi};
    unique case (state)
      dvrt_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        if (&clr_cnt) begin
          state_next = dvrt_pkg::ST_IDLE;
        end
      end
      dvrt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = ign_c ? dvrt_pkg::ST_DONE : dvrt_pkg::ST_LOOKUP;
        end
      end
      dvrt_pkg::ST_LOOKUP: begin
        state_next = (op_q == dvrt_pkg::OP_REMOVE_LINK) ? dvrt_pkg::ST_COLUMN
                                                         : dvrt_pkg::ST_UPDATE;
      end
      dvrt_pkg::ST_UPDATE: begin
        ram_we     = 1'b1;
        ram_wdata  = wval;
        state_next = dvrt_pkg::ST_SCAN;
      end
      dvrt_pkg::ST_COLUMN: begin
        // read-first RAM: old entry comes back while INF goes in
        ram_waddr = {cnt[NODE_W-1:0], nbi};
        ram_raddr = {cnt[NODE_W-1:0], nbi};
        if (cnt < MAX_CNT) begin
          ram_we = 1'b1;
        end else begin
          state_next = dvrt_pkg::ST_SCAN;
        end
      end
      dvrt_pkg::ST_SCAN: begin
        ram_raddr = {scan_row, cnt[NODE_W-1:0]};
        if (cnt >= n_eff) begin
          state_next = dvrt_pkg::ST_ROW_DONE;
        end
      end
      dvrt_pkg::ST_ROW_DONE: begin
        if ((op_q == dvrt_pkg::OP_REMOVE_LINK) && (CMP_W'(scan_row) + 1'b1 < n_eff)) begin
          state_next = dvrt_pkg::ST_SCAN;
        end else begin
          state_next = dvrt_pkg::ST_DONE;
        end
      end
      dvrt_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = dvrt_pkg::ST_IDLE;
        end
      end
      default: state_next = dvrt_pkg::ST_IDLE;
    endcase
  end

  // clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == dvrt_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // neighbor flags and row minima
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        neighbor_valid[i] <= 1'b0;
        row_minimum[i]    <= INF;
      end
    end else begin
      if (state == dvrt_pkg::ST_LOOKUP) begin
        if (op_q == dvrt_pkg::OP_SET_LINK) begin
          neighbor_valid[nbi] <= 1'b1;
        end else if (op_q == dvrt_pkg::OP_REMOVE_LINK) begin
          neighbor_valid[nbi] <= 1'b0;
        end
      end
      if (state == dvrt_pkg::ST_ROW_DONE) begin
        row_minimum[scan_row] <= m_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == dvrt_pkg::ST_LOOKUP && op_q == dvrt_pkg::OP_SET_LINK) begin
      link_cost[nbi] <= cv_q;
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state)
      dvrt_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_q      <= opcode;
          nb_q      <= neighbor;
          ds_q      <= destination;
          cv_q      <= COST_BITS'(cost_value);
          ign_q     <= ign_c;
          chg       <= 1'b0;
          res_best  <= INF;
          res_hop   <= '0;
          res_route <= 1'b0;
        end
      end
      dvrt_pkg::ST_LOOKUP: begin
        wval <= (op_q == dvrt_pkg::OP_ADVERTISE) ? sat_sum : cv_q;
        cnt  <= '0;
        pend <= 1'b0;
      end
      dvrt_pkg::ST_UPDATE: begin
        if (rd_data != wval) begin
          chg <= 1'b1;
        end
        scan_row <= row_i;
        cnt      <= '0;
        pend     <= 1'b0;
        m_acc    <= INF;
        hop_acc  <= '0;
      end
      dvrt_pkg::ST_COLUMN: begin
        if (pend && (rd_data != INF)) begin
          chg <= 1'b1;
        end
        if (cnt < MAX_CNT) begin
          cnt  <= cnt + 1'b1;
          pend <= 1'b1;
        end else begin
          scan_row <= '0;
          cnt      <= '0;
          pend     <= 1'b0;
          m_acc    <= INF;
          hop_acc  <= '0;
        end
      end
      dvrt_pkg::ST_SCAN: begin
        // strict compare keeps the lowest via on a tie
        if (pend && (cand < m_acc)) begin
          m_acc   <= cand;
          hop_acc <= pend_via;
        end
        if (cnt < n_eff) begin
          cnt      <= cnt + 1'b1;
          pend     <= 1'b1;
          pend_via <= cnt[NODE_W-1:0];
        end else begin
          pend <= 1'b0;
        end
      end
      dvrt_pkg::ST_ROW_DONE: begin
        if (m_acc != row_minimum[scan_row]) begin
          chg <= 1'b1;
        end
        if (scan_row == row_i) begin
          res_best  <= m_acc;
          res_hop   <= hop_acc;
          res_route <= (m_acc != INF);
        end
        scan_row <= scan_row + 1'b1;
        cnt      <= '0;
        pend     <= 1'b0;
        m_acc    <= INF;
        hop_acc  <= '0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      route_dest <= link_op ? nb_q : ds_q;
      best_cost  <= dvrt_pkg::PORT_COST_W'(res_best);
      next_hop   <= dvrt_pkg::IDX_W'(res_hop);
      reachable  <= res_route;
      changed    <= chg && !ign_q;
      ignored    <= ign_q;
    end
  end

endmodule

// ===== tb/tb_distance_vector_route_table.sv =====
// Self-checking testbench for distance_vector_route_table: directed and random
// items through both channels, predicted results compared beat by beat.
// Depends on dvrt_pkg and the RTL of the route table.
module tb_distance_vector_route_table;

  localparam logic [dvrt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [15:0] INF_COST = 16'hFFFF;
  localparam int NODES = 32;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [4:0]  dest;
    logic [15:0] cost;
    logic [4:0]  hop;
    logic        reachable;
    logic        changed;
    logic        ignored;
  } route_result_t;

  // Route table predictor plus the queue of routes still owed by the block
  class route_scoreboard;
    logic [15:0] dv_cost [NODES][NODES];
    bit          via_valid [NODES];
    logic [15:0] link [NODES];
    logic [15:0] row_min [NODES];
    logic [4:0]  own;
    logic [5:0]  count;
    route_result_t owed_q[$];
    int errors;

    function new();
      for (int d = 0; d < NODES; d++) begin
        for (int v = 0; v < NODES; v++) dv_cost[d][v] = INF_COST;
        via_valid[d] = 0;
        link[d] = 16'd0;
        row_min[d] = INF_COST;
      end
      own = 5'd0;
      count = dvrt_pkg::NODE_COUNT_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [dvrt_pkg::CFG_IDX_W-1:0] idx,
                            logic [dvrt_pkg::CFG_W-1:0] val);
      if (idx == dvrt_pkg::CFG_OWN_INDEX) own = val[4:0];
      else count = val;
    endfunction

    function int active();
      return (count > NODES) ? NODES : int'(count);
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    function logic [15:0] add_sat(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= {1'b0, INF_COST}) ? INF_COST : s[15:0];
    endfunction

    // minimum over every via below the active count, valid or not
    function bit rescan_row(int d);
      logic [15:0] m;
      bit moved;
      m = INF_COST;
      for (int v = 0; v < active(); v++)
        if (dv_cost[d][v] < m) m = dv_cost[d][v];
      moved = (m != row_min[d]);
      row_min[d] = m;
      return moved;
    endfunction

    function void note_item(logic [dvrt_pkg::OP_W-1:0] op, logic [4:0] nb, logic [4:0] ds,
                            logic [15:0] cv);
      route_result_t r;
      int n;
      bit skip;
      bit moved;
      logic [15:0] nc;
      logic [15:0] hop_cost;
      n = active();
      skip = 1;
      moved = 0;
      r.dest = (op == dvrt_pkg::OP_SET_LINK || op == dvrt_pkg::OP_REMOVE_LINK) ? nb : ds;
      case (op)
        dvrt_pkg::OP_ADVERTISE: begin
          if (nb < n && ds < n && ds != own && via_valid[nb]) begin
            skip = 0;
            nc = add_sat(link[nb], cv);
            if (dv_cost[ds][nb] != nc) moved = 1;
            dv_cost[ds][nb] = nc;
            if (rescan_row(ds)) moved = 1;
          end
        end
        dvrt_pkg::OP_SET_LINK: begin
          if (nb < n && nb != own) begin
            skip = 0;
            via_valid[nb] = 1;
            link[nb] = cv;
            if (dv_cost[nb][nb] != cv) moved = 1;
            dv_cost[nb][nb] = cv;
            if (rescan_row(nb)) moved = 1;
          end
        end
        dvrt_pkg::OP_REMOVE_LINK: begin
          if (nb < n && nb != own) begin
            skip = 0;
            via_valid[nb] = 0;
            // column cleared in all rows, only active rows rescanned
            for (int d = 0; d < NODES; d++) begin
              if (dv_cost[d][nb] != INF_COST) moved = 1;
              dv_cost[d][nb] = INF_COST;
            end
            for (int d = 0; d < n; d++)
              if (rescan_row(d)) moved = 1;
          end
        end
        default: ;
      endcase
      r.cost = INF_COST;
      r.hop = 5'd0;
      r.reachable = 1'b0;
      r.changed = 1'b0;
      r.ignored = skip;
      if (!skip) begin
        r.cost = row_min[r.dest];
        r.changed = moved;
        hop_cost = INF_COST;
        for (int v = 0; v < n; v++) begin
          if (via_valid[v] && dv_cost[r.dest][v] < hop_cost) begin
            hop_cost = dv_cost[r.dest][v];
            r.hop = 5'(v);
            r.reachable = 1'b1;
          end
        end
      end
      owed_q.push_back(r);
    endfunction

    function void cmp(string what, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $display("%0t: %s expected %0d got %0d", $time, what, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_result(route_result_t got);
      route_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected route beat, dest %0d cost %0d", $time, got.dest,
                 got.cost);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      cmp("route_dest", int'(want.dest), int'(got.dest));
      cmp("best_cost", int'(want.cost), int'(got.cost));
      cmp("next_hop", int'(want.hop), int'(got.hop));
      cmp("reachable", int'(want.reachable), int'(got.reachable));
      cmp("changed", int'(want.changed), int'(got.changed));
      cmp("ignored", int'(want.ignored), int'(got.ignored));
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [dvrt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dvrt_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [dvrt_pkg::OP_W-1:0] opcode = '0;
  logic [dvrt_pkg::IDX_W-1:0] neighbor = '0;
  logic [dvrt_pkg::IDX_W-1:0] destination = '0;
  logic [dvrt_pkg::PORT_COST_W-1:0] cost_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [dvrt_pkg::IDX_W-1:0] route_dest;
  logic [dvrt_pkg::PORT_COST_W-1:0] best_cost;
  logic [dvrt_pkg::IDX_W-1:0] next_hop;
  logic reachable, changed, ignored;

  route_scoreboard sb;
  int tx_idle_pct = 21;
  int rx_idle_pct = 80;
  int unsigned cycle_count = 0;

  distance_vector_route_table dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .neighbor(neighbor), .destination(destination),
    .cost_value(cost_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .route_dest(route_dest), .best_cost(best_cost), .next_hop(next_hop),
    .reachable(reachable), .changed(changed), .ignored(ignored)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_distance_vector_route_table: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{route_dest, best_cost, next_hop, reachable, changed, ignored});
  end

  task automatic write_cfg(input logic [dvrt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dvrt_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // valid stays up across back-to-back beats; only dropped for a gap
  task automatic send_item(input logic [dvrt_pkg::OP_W-1:0] op, input logic [4:0] nb,
                           input logic [4:0] ds, input logic [15:0] cv);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    neighbor <= nb;
    destination <= ds;
    cost_value <= cv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, nb, ds, cv);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 30));
      1: return INF_COST;
      2: return 16'($urandom_range(65500, 65535));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic run_directed();
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd4, 5'd9, 16'd10);     // sender not a neighbor yet
    send_item(dvrt_pkg::OP_SET_LINK, 5'd0, 5'd0, 16'd3);       // link to self
    send_item(dvrt_pkg::OP_SET_LINK, 5'd4, 5'd0, 16'd10);
    send_item(dvrt_pkg::OP_SET_LINK, 5'd31, 5'd0, 16'd0);
    send_item(dvrt_pkg::OP_SET_LINK, 5'd2, 5'd0, INF_COST);    // infinite link
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd4, 5'd9, 16'd5);
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd31, 5'd9, 16'd15);    // tie, lower index wins
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd31, 5'd9, 16'd15);    // no change
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd4, 5'd9, INF_COST);
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd4, 5'd20, 16'd65530); // sum saturates
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd4, 5'd20, 16'd65524); // one below infinity
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd2, 5'd9, 16'd0);
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd4, 5'd0, 16'd1);      // destination is self
    send_item(OP_UNUSED, 5'd4, 5'd9, 16'd1);
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd31, 5'd31, 16'hFFFE);
    send_item(dvrt_pkg::OP_REMOVE_LINK, 5'd31, 5'd31, 16'd0);
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd31, 5'd9, 16'd1);     // removed neighbor
    send_item(dvrt_pkg::OP_REMOVE_LINK, 5'd0, 5'd0, 16'd0);    // self
    send_item(dvrt_pkg::OP_SET_LINK, 5'd31, 5'd0, INF_COST);
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd4, 5'd31, 16'd0);
    send_item(dvrt_pkg::OP_REMOVE_LINK, 5'd6, 5'd0, 16'd0);    // never linked
    send_item(dvrt_pkg::OP_SET_LINK, 5'd4, 5'd0, 16'd0);
    send_item(dvrt_pkg::OP_ADVERTISE, 5'd4, 5'd9, 16'd0);
  endtask

  task automatic run_random(input int n_items);
    int live[$];
    int n;
    int r;
    logic [dvrt_pkg::OP_W-1:0] op;
    logic [4:0] nb;
    logic [4:0] ds;
    for (int i = 0; i < n_items; i++) begin
      n = sb.active();
      live.delete();
      for (int v = 0; v < n; v++)
        if (sb.via_valid[v]) live.push_back(v);
      r = $urandom_range(0, 99);
      if (live.size() < 3 && r < 60) op = dvrt_pkg::OP_SET_LINK;
      else if (r < 70) op = dvrt_pkg::OP_ADVERTISE;
      else if (r < 88) op = dvrt_pkg::OP_SET_LINK;
      else if (r < 95) op = dvrt_pkg::OP_REMOVE_LINK;
      else op = OP_UNUSED;
      // mostly well-formed: known neighbors, in-range destinations
      if (live.size() > 0 && op != dvrt_pkg::OP_SET_LINK && $urandom_range(0, 9) < 8)
        nb = 5'(live[$urandom_range(0, live.size() - 1)]);
      else if (n > 0 && $urandom_range(0, 9) < 8)
        nb = 5'($urandom_range(0, n - 1));
      else
        nb = 5'($urandom_range(0, 31));
      if (n > 0 && $urandom_range(0, 9) < 9) ds = 5'($urandom_range(0, n - 1));
      else ds = 5'($urandom_range(0, 31));
      send_item(op, nb, ds, pick_cost());
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_cfg(dvrt_pkg::CFG_OWN_INDEX, 6'd0);
    write_cfg(dvrt_pkg::CFG_NODE_COUNT, 6'd32);
    run_directed();
    drain();

    write_cfg(dvrt_pkg::CFG_OWN_INDEX, 6'd31);
    write_cfg(dvrt_pkg::CFG_NODE_COUNT, 6'd63);  // above the table size, acts as full
    run_random(140);
    drain();

    tx_idle_pct = 80;
    rx_idle_pct = 21;
    write_cfg(dvrt_pkg::CFG_OWN_INDEX, 6'd3);
    write_cfg(dvrt_pkg::CFG_NODE_COUNT, 6'd6);
    run_random(110);
    drain();
    write_cfg(dvrt_pkg::CFG_OWN_INDEX, 6'd0);
    write_cfg(dvrt_pkg::CFG_NODE_COUNT, 6'd1);
    run_random(20);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_cfg(dvrt_pkg::CFG_OWN_INDEX, 6'd7);
    write_cfg(dvrt_pkg::CFG_NODE_COUNT, 6'd0);   // every item rejected
    run_random(10);
    drain();
    write_cfg(dvrt_pkg::CFG_OWN_INDEX, 6'd12);
    write_cfg(dvrt_pkg::CFG_NODE_COUNT, 6'd20);
    run_random(170);
    drain();

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("tb_distance_vector_route_table: clean");
    else
      $display("tb_distance_vector_route_table: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dvrt_pkg.sv
rtl/dvrt_ram.sv
rtl/distance_vector_route_table.sv
tb/tb_distance_vector_route_table.sv
